>>> rtl/u8d_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 decoder.
package u8d_pkg;

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int QUEUE_D  = 3;
    localparam int TDATA_W  = 24;

    localparam logic [CP_W-1:0]   REPLACEMENT_CP = 21'h00FFFD;

    localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE  = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_CODE   = 8'h80;
    localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h3F;

    typedef enum logic {
        ST_INPUT,
        ST_REPLAY
    } t_state;

    typedef struct packed {
        logic take_input;
        logic take_replay;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic queue_empty;
        logic queue_empty_next;
    } t_status;

endpackage

>>> rtl/utf8_decoder_with_replacement_top.sv
`timescale 1ns / 1ps
// Top level of the UTF-8 decoder with U+FFFD replacement.
//
// Input stream: one UTF-8 byte per transfer in s_axis_tdata, s_axis_tlast
// marks the last byte of a string. Output stream: one codepoint per transfer
// in m_axis_tdata[20:0], m_axis_tuser = 1 when the codepoint is U+FFFD put in
// for malformed input, m_axis_tlast on the last codepoint of the string.
// The result sits in the output register in the cycle after the byte that
// completes it is taken. Throughput: one byte per cycle while bytes decode
// cleanly and the receiver keeps up. When a multi-byte sequence turns out to
// hold a bad continuation, the bytes after its lead are decoded again from a
// three-deep replay queue, one per cycle while the receiver keeps up; nested
// failures during replay put bytes back in the queue and keep input waiting.
// A string that ends inside an open sequence yields one U+FFFD with tlast,
// registered when the last byte (and any replay it caused) is decoded.
// Reset (synchronous, active low) clears the sequence state, the replay
// queue and the output valid flag. If the receiver stalls, the single
// output register holds its result and input stops; no result is dropped.
module utf8_decoder_with_replacement_top
    import u8d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic               s_axis_tlast,   // end_of_string
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic               m_axis_tuser,   // [0] replaced
    output logic               m_axis_tlast    // final_result
);

    t_cmd            cmd;
    t_status         status;
    t_state          state;
    logic [CP_W-1:0] cp;

    u8d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_state    (state)
    );

    u8d_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_cp        (cp),
        .o_repl      (m_axis_tuser),
        .o_final     (m_axis_tlast)
    );

    assign m_axis_tdata = {{(TDATA_W-CP_W){1'b0}}, cp};

    // Input is only taken when no replayed byte is waiting.
    a_ready_only_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> status.queue_empty)
        else $error("input ready while replay queue holds bytes");

    // Replay state never takes from an empty queue.
    a_replay_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.take_replay |-> (state == ST_REPLAY) && !status.queue_empty)
        else $error("replay issued with empty queue");

    // Only one byte source per cycle.
    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.take_input && cmd.take_replay))
        else $error("input and replay taken together");

    // A final codepoint closes the string: the replay queue is empty after it.
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast && !$past(m_axis_tvalid)) |->
            status.queue_empty)
        else $error("final result with replay bytes left");

endmodule

>>> rtl/u8d_ctrl.sv
`timescale 1ns / 1ps
// Controller: picks the byte source each cycle (input stream or replay queue).
module u8d_ctrl
    import u8d_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output t_state  o_state
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INPUT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_in_ready        = 1'b0;
        o_cmd.take_input  = 1'b0;
        o_cmd.take_replay = 1'b0;
        unique case (r_state)
            ST_INPUT: begin
                o_in_ready       = i_status.out_free;
                o_cmd.take_input = i_in_valid && i_status.out_free;
                if (o_cmd.take_input && !i_status.queue_empty_next) begin
                    n_state = ST_REPLAY;
                end
            end
            ST_REPLAY: begin
                o_cmd.take_replay = i_status.out_free;
                if (i_status.out_free && i_status.queue_empty_next) begin
                    n_state = ST_INPUT;
                end
            end
            default: n_state = ST_INPUT;
        endcase
    end

    assign o_state = r_state;

endmodule

>>> rtl/u8d_datapath.sv
`timescale 1ns / 1ps
// Datapath: sequence state, held bytes, replay queue and output register.
module u8d_datapath
    import u8d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [BYTE_W-1:0] i_data,
    input  logic              i_last,
    input  logic              i_out_ready,
    output t_status           o_status,
    output logic              o_out_valid,
    output logic [CP_W-1:0]   o_cp,
    output logic              o_repl,
    output logic              o_final
);

    logic [BYTE_W-1:0] r_lead, n_lead;
    logic [1:0]        r_need, n_need;
    logic [1:0]        r_held, n_held;
    logic [BYTE_W-1:0] r_h [QUEUE_D];
    logic [BYTE_W-1:0] n_h [QUEUE_D];
    logic [BYTE_W-1:0] r_rq [QUEUE_D];
    logic [BYTE_W-1:0] n_rq [QUEUE_D];
    logic [1:0]        r_rq_cnt, n_rq_cnt;
    logic              r_eos;
    logic              r_out_valid;
    logic [CP_W-1:0]   r_cp;
    logic              r_repl;
    logic              r_final;

    logic              step_go;
    logic [BYTE_W-1:0] cur;
    logic              eos_step;
    logic [1:0]        rest_cnt;
    logic [BYTE_W-1:0] h_full [QUEUE_D];
    logic              fail;
    logic              all_cont;
    logic              res_valid;
    logic [CP_W-1:0]   res_cp;
    logic              res_repl;
    logic              step_end;

    assign step_go = i_cmd.take_input || i_cmd.take_replay;

    always_comb begin
        cur       = i_cmd.take_input ? i_data : r_rq[0];
        eos_step  = i_cmd.take_input ? i_last : r_eos;
        rest_cnt  = i_cmd.take_replay ? (r_rq_cnt - 2'd1) : 2'd0;
        n_lead    = r_lead;
        n_need    = r_need;
        n_held    = r_held;
        n_h       = r_h;
        h_full    = r_h;
        h_full[r_held] = cur;
        fail      = 1'b0;
        all_cont  = 1'b1;
        res_valid = 1'b0;
        res_cp    = '0;
        res_repl  = 1'b0;

        for (int k = 0; k < QUEUE_D; k++) begin
            if (2'(k) < r_need && (h_full[k] & CONT_MASK) != CONT_CODE) begin
                all_cont = 1'b0;
            end
        end

        if (step_go) begin
            if (r_need == 2'd0) begin
                if (cur < ASCII_LIMIT) begin
                    res_valid = 1'b1;
                    res_cp    = {{(CP_W-BYTE_W){1'b0}}, cur};
                end else if ((cur & LEAD2_MASK) == LEAD2_CODE) begin
                    n_lead = cur; n_need = 2'd1; n_held = 2'd0;
                end else if ((cur & LEAD3_MASK) == LEAD3_CODE) begin
                    n_lead = cur; n_need = 2'd2; n_held = 2'd0;
                end else if ((cur & LEAD4_MASK) == LEAD4_CODE) begin
                    n_lead = cur; n_need = 2'd3; n_held = 2'd0;
                end else begin
                    res_valid = 1'b1;
                    res_cp    = REPLACEMENT_CP;
                    res_repl  = 1'b1;
                end
            end else begin
                n_h[r_held] = cur;
                if (r_held + 2'd1 != r_need) begin
                    n_held = r_held + 2'd1;
                end else begin
                    // sequence complete: check all continuations, then assemble
                    n_need    = 2'd0;
                    n_held    = 2'd0;
                    res_valid = 1'b1;
                    if (all_cont) begin
                        unique case (r_need)
                            2'd1: res_cp = {10'd0, r_lead[4:0], h_full[0][5:0]};
                            2'd2: res_cp = {5'd0, r_lead[3:0], h_full[0][5:0],
                                            h_full[1][5:0]};
                            default: res_cp = {r_lead[2:0], h_full[0][5:0],
                                               h_full[1][5:0], h_full[2][5:0]};
                        endcase
                    end else begin
                        fail     = 1'b1;
                        res_cp   = REPLACEMENT_CP;
                        res_repl = 1'b1;
                    end
                end
            end
        end

        // replay queue: failed continuations go in front of what is left
        n_rq = r_rq;
        if (step_go) begin
            if (fail) begin
                n_rq_cnt = r_need + rest_cnt;
                for (int i = 0; i < QUEUE_D; i++) begin
                    if (2'(i) < r_need) begin
                        n_rq[i] = h_full[i];
                    end else begin
                        n_rq[i] = r_rq[2'(i + 1) - r_need];
                    end
                end
            end else begin
                n_rq_cnt = rest_cnt;
                n_rq[0]  = r_rq[1];
                n_rq[1]  = r_rq[2];
            end
        end else begin
            n_rq_cnt = r_rq_cnt;
        end

        step_end = step_go && eos_step && (n_rq_cnt == 2'd0);
        // string ended inside an open sequence
        if (step_end && !res_valid && n_need != 2'd0) begin
            res_valid = 1'b1;
            res_cp    = REPLACEMENT_CP;
            res_repl  = 1'b1;
        end
        if (step_end) begin
            n_need = 2'd0;
            n_held = 2'd0;
            n_lead = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead      <= '0;
            r_need      <= 2'd0;
            r_held      <= 2'd0;
            r_rq_cnt    <= 2'd0;
            r_eos       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_lead   <= n_lead;
            r_need   <= n_need;
            r_held   <= n_held;
            r_rq_cnt <= n_rq_cnt;
            if (i_cmd.take_input) begin
                r_eos <= i_last;
            end
            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_h  <= n_h;
        r_rq <= n_rq;
        if (res_valid) begin
            r_cp    <= res_cp;
            r_repl  <= res_repl;
            r_final <= step_end;
        end
    end

    assign o_status.out_free         = !r_out_valid || i_out_ready;
    assign o_status.queue_empty      = (r_rq_cnt == 2'd0);
    assign o_status.queue_empty_next = (n_rq_cnt == 2'd0);
    assign o_out_valid = r_out_valid;
    assign o_cp        = r_cp;
    assign o_repl      = r_repl;
    assign o_final     = r_final;

endmodule
